// File: hdl/dlrt_pkg.sv
// ----------------------------------------------------------------------------
// dlrt_pkg
// Shared types and constants of the dirty line run tracker.
// ----------------------------------------------------------------------------
package dlrt_pkg;

    localparam int MAX_LINES    = 256;
    localparam int MAX_RUNS     = 16;
    localparam int RESULT_LIMIT = 16;
    localparam int RUN_LIMIT    = (MAX_RUNS < RESULT_LIMIT) ? MAX_RUNS : RESULT_LIMIT;

    localparam int LINE_W  = 8;
    localparam int COUNT_W = 9;
    localparam int MODE_W  = 2;
    localparam int LIU_W   = 9;
    localparam int MRUN_W  = 5;
    localparam int CFG_W   = 9;
    localparam int RUNN_W  = $clog2(RUN_LIMIT + 1);

    typedef enum logic [MODE_W-1:0] {
        MODE_MARK  = 2'd0,
        MODE_CLEAR = 2'd1,
        MODE_QUERY = 2'd2,
        MODE_EMIT  = 2'd3
    } mode_t;

    typedef enum logic {
        REG_LINES_IN_USE = 1'b0,
        REG_MAX_RUNS     = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [LINE_W-1:0] line;
    } dlrt_req_t;

    typedef struct packed {
        logic               line_is_dirty;
        logic               run_valid;
        logic [LINE_W-1:0]  run_first;
        logic [COUNT_W-1:0] run_count;
        logic               last_result;
    } dlrt_rsp_t;

    typedef struct packed {
        logic               valid;
        logic [LINE_W-1:0]  first;
        logic [COUNT_W-1:0] count;
    } dlrt_run_t;

endpackage

// File: hdl/dlrt_ram.sv
// ----------------------------------------------------------------------------
// dlrt_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module dlrt_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hdl/dlrt_run_acc.sv
// ----------------------------------------------------------------------------
// dlrt_run_acc
// Run builder: folds scanned dirty bits into runs and closes finished runs.
// ----------------------------------------------------------------------------
module dlrt_run_acc (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic                       step,
    input  logic                       dirty,
    input  logic [dlrt_pkg::LINE_W-1:0] idx,
    input  logic [dlrt_pkg::RUNN_W-1:0] limit,
    output dlrt_pkg::dlrt_run_t        closed,
    output dlrt_pkg::dlrt_run_t        current
);

    import dlrt_pkg::*;

    logic [LINE_W-1:0]  first_reg, first_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [RUNN_W-1:0]  n_reg, n_next;
    logic [COUNT_W:0]   run_end;
    logic               adjacent;

    assign run_end  = {2'b00, first_reg} + {1'b0, count_reg};
    assign adjacent = (n_reg != '0) && (run_end == {2'b00, idx});

    always_comb begin
        first_next   = first_reg;
        count_next   = count_reg;
        n_next       = n_reg;
        closed.valid = 1'b0;
        closed.first = first_reg;
        closed.count = count_reg;
        if (start) begin
            n_next = '0;
        end else if (step && dirty) begin
            if (adjacent) begin
                count_next = count_reg + 1'b1;
            end else if (n_reg < limit) begin
                closed.valid = (n_reg != '0);
                first_next   = idx;
                count_next   = COUNT_W'(1);
                n_next       = n_reg + 1'b1;
            end else begin
                count_next = {1'b0, idx} - {1'b0, first_reg} + 1'b1;
            end
        end
    end

    assign current.valid = (n_reg != '0);
    assign current.first = first_reg;
    assign current.count = count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg <= '0;
        end else begin
            n_reg <= n_next;
        end
        first_reg <= first_next;
        count_reg <= count_next;
    end

endmodule

// File: hdl/dirty_line_run_tracker.sv
// ----------------------------------------------------------------------------
// dirty_line_run_tracker
// Dirty bit store per display line with mark, clear, query and run scan.
// ----------------------------------------------------------------------------
// Requests enter on s_valid/s_ready with s_data (mode, line); results leave
// on m_valid/m_ready with m_data. Configuration is a plain write port.
// Mark: no result; back-to-back marks run at one per cycle. Clear: writes
// zero through the 256-entry bit RAM, one entry per cycle, and the next
// request is taken only once the pass ends. Query: one read of the RAM; the
// result is loaded into the output register from the query state once that
// register is free, and the block then returns to idle for the next request.
// Scan: one RAM read per line in use, a two-stage read/evaluate loop; each
// run closed during the sweep is emitted as it closes, the final one at the
// end. Reset runs a clearing pass over all 256 entries with s_ready low;
// config writes are taken throughout. While the receiver stalls, the output
// register holds its result and a scan pauses until the output register is
// free.
// ----------------------------------------------------------------------------
module dirty_line_run_tracker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  dlrt_pkg::dlrt_req_t         s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output dlrt_pkg::dlrt_rsp_t         m_data,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [dlrt_pkg::CFG_W-1:0]  cfg_wdata
);

    import dlrt_pkg::*;

    localparam int ADDR_W = $clog2(MAX_LINES);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_QUERY,
        ST_SCAN
    } state_t;

    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  clr_idx_reg, clr_idx_next;
    logic [LIU_W-1:0]   scan_idx_reg, scan_idx_next;
    logic               pend_reg, pend_next;
    logic [LINE_W-1:0]  pidx_reg, pidx_next;
    logic               qok_reg, qok_next;
    logic               m_valid_reg, m_valid_next;
    dlrt_rsp_t          m_data_reg, m_data_next;
    logic [LIU_W-1:0]   lines_reg;
    logic [MRUN_W-1:0]  runs_reg;

    logic [LIU_W-1:0]   nl;
    logic [RUNN_W-1:0]  limit;
    logic               in_range;
    logic               accept;
    logic               can_emit;
    logic               issue;
    logic               proc;
    logic               acc_start;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic               ram_wdata;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic               ram_rdata;
    dlrt_run_t          closed;
    dlrt_run_t          current;

    assign nl = (lines_reg > LIU_W'(MAX_LINES)) ? LIU_W'(MAX_LINES) : lines_reg;
    assign limit = (runs_reg > MRUN_W'(RUN_LIMIT)) ? RUNN_W'(RUN_LIMIT)
                                                   : RUNN_W'(runs_reg);
    assign in_range = ({1'b0, s_data.line} < nl);
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign can_emit = !m_valid_reg || m_ready;
    assign proc     = (state_reg == ST_SCAN) && pend_reg && can_emit;
    assign issue    = (state_reg == ST_SCAN) && (scan_idx_reg < nl) && (!pend_reg || proc);
    assign acc_start = accept && (mode_t'(s_data.mode) == MODE_EMIT);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = s_data.line;
        ram_wdata = 1'b1;
        ram_re    = 1'b0;
        ram_raddr = s_data.line;
        if (state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_idx_reg;
            ram_wdata = 1'b0;
        end else if (accept && mode_t'(s_data.mode) == MODE_MARK) begin
            ram_we = in_range;
        end
        if (accept && mode_t'(s_data.mode) == MODE_QUERY) begin
            ram_re = 1'b1;
        end else if (issue) begin
            ram_re    = 1'b1;
            ram_raddr = scan_idx_reg[ADDR_W-1:0];
        end
    end

    dlrt_ram #(
        .WIDTH (1),
        .DEPTH (MAX_LINES)
    ) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    dlrt_run_acc u_acc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (acc_start),
        .step    (proc),
        .dirty   (ram_rdata),
        .idx     (pidx_reg),
        .limit   (limit),
        .closed  (closed),
        .current (current)
    );

    always_comb begin
        state_next    = state_reg;
        clr_idx_next  = clr_idx_reg;
        scan_idx_next = scan_idx_reg;
        pend_next     = pend_reg;
        pidx_next     = pidx_reg;
        qok_next      = qok_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == ADDR_W'(MAX_LINES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    unique case (mode_t'(s_data.mode))
                        MODE_MARK: state_next = ST_IDLE;
                        MODE_CLEAR: begin
                            clr_idx_next = '0;
                            state_next   = ST_CLEAR;
                        end
                        MODE_QUERY: begin
                            qok_next   = in_range;
                            state_next = ST_QUERY;
                        end
                        MODE_EMIT: begin
                            scan_idx_next = '0;
                            pend_next     = 1'b0;
                            state_next    = ST_SCAN;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_QUERY: begin
                if (can_emit) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    m_data_next.line_is_dirty = ram_rdata && qok_reg;
                    m_data_next.last_result   = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (proc && closed.valid) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    m_data_next.run_valid = 1'b1;
                    m_data_next.run_first = closed.first;
                    m_data_next.run_count = closed.count;
                end
                if (issue) begin
                    pend_next     = 1'b1;
                    pidx_next     = scan_idx_reg[LINE_W-1:0];
                    scan_idx_next = scan_idx_reg + 1'b1;
                end else if (proc) begin
                    pend_next = 1'b0;
                end
                if (!pend_reg && !(scan_idx_reg < nl) && can_emit) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    m_data_next.run_valid   = current.valid;
                    m_data_next.run_first   = current.valid ? current.first : '0;
                    m_data_next.run_count   = current.valid ? current.count : '0;
                    m_data_next.last_result = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_idx_reg  <= '0;
            scan_idx_reg <= '0;
            pend_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
            lines_reg    <= LIU_W'(256);
            runs_reg     <= MRUN_W'(16);
        end else begin
            state_reg    <= state_next;
            clr_idx_reg  <= clr_idx_next;
            scan_idx_reg <= scan_idx_next;
            pend_reg     <= pend_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_we) begin
                unique case (cfg_index_t'(cfg_index))
                    REG_LINES_IN_USE: lines_reg <= cfg_wdata[LIU_W-1:0];
                    REG_MAX_RUNS:     runs_reg  <= cfg_wdata[MRUN_W-1:0];
                    default:          lines_reg <= lines_reg;
                endcase
            end
        end
        pidx_reg   <= pidx_next;
        qok_reg    <= qok_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
